/* hw/rtl/mss_pkg.sv */
package mss_pkg;

  // Default number of array elements held by the tree.
  localparam int unsigned CAPACITY_DEF = 1024;

  // Fixed field widths of the transactions.
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned BEST_W  = 41;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 3;

  // Reset value of the element count register.
  localparam logic [CNT_W-1:0] EC_RESET = 11'd1024;

  // Register index, taken from paddr[2].
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  // Action codes of an input transaction.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Engine sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WDOWN,
    ST_WUPRD,
    ST_WUPWR,
    ST_QSTEP,
    ST_QTAIL,
    ST_DONE
  } state_e;

endpackage

/* hw/rtl/mss_ram.sv */
module mss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/mss_apb.sv */
module mss_apb
  import mss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output logic [CNT_W-1:0]   element_count_o
);

  logic [CNT_W-1:0] ec_q, ec_d;
  logic             sel_ec;

  assign pready = 1'b1;
  assign sel_ec = (paddr[2] == REG_ELEMENT_COUNT);

  // Register write in the access phase of a transaction.
  always_comb begin
    ec_d = ec_q;
    if (psel && penable && pwrite && sel_ec) begin
      ec_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q <= EC_RESET;
    end else begin
      ec_q <= ec_d;
    end
  end

  // Read back.
  assign prdata = sel_ec ? {{(DATA_W-CNT_W){1'b0}}, ec_q} : '0;
  assign element_count_o = ec_q;

endmodule

/* hw/rtl/mss_engine.sv */
module mss_engine
  import mss_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned IW       = $clog2(CAPACITY),
  parameter int unsigned AW       = $clog2(2 * CAPACITY),
  parameter int unsigned NW       = VAL_W + $clog2(CAPACITY)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [CNT_W-1:0]        element_count_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    action_i,
  input  logic [IDX_W-1:0]        first_index_i,
  input  logic [IDX_W-1:0]        last_index_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [BEST_W-1:0]       best_sum_o,
  output logic                    range_error_o,
  output logic                    mem_we_o,
  output logic [AW-1:0]           mem_waddr_o,
  output logic [4*NW-1:0]         mem_wdata_o,
  output logic                    mem_re_o,
  output logic [AW-1:0]           mem_raddr_o,
  input  logic [4*NW-1:0]         mem_rdata_i
);

  localparam int unsigned SD  = IW + 1;
  localparam int unsigned PW  = $clog2(SD);
  localparam int unsigned SPW = $clog2(SD + 1);

  typedef struct packed {
    logic signed [NW-1:0] tot;
    logic signed [NW-1:0] pre;
    logic signed [NW-1:0] suf;
    logic signed [NW-1:0] inn;
  } span_t;

  function automatic logic signed [NW-1:0] smax(logic signed [NW-1:0] a,
                                               logic signed [NW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Combine the spans of two adjacent segments, left one first.
  function automatic span_t span_merge(span_t a, span_t b);
    span_t s;
    s.tot = a.tot + b.tot;
    s.pre = smax(a.pre, a.tot + b.pre);
    s.suf = smax(b.suf, b.tot + a.suf);
    s.inn = smax(smax(a.inn, b.inn), a.suf + b.pre);
    return s;
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [AW-1:0]  v_q, v_d;
  logic [IW-1:0]  tl_q, tl_d, tr_q, tr_d, l_q, l_d, r_q, r_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic           err_q, err_d;
  logic           rd_pend_q, rd_pend_d;
  span_t          acc_q, acc_d, carry_q, carry_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [PW-1:0]  wd_q, wd_d;
  logic           out_valid_q, out_valid_d, out_err_q, out_err_d;
  logic [BEST_W-1:0] out_best_q, out_best_d;

  // Traversal stack of pending right subtrees, and the write path.
  logic [AW-1:0] stk_v [SD];
  logic [IW-1:0] stk_tl [SD];
  logic [IW-1:0] stk_tr [SD];
  logic [IW-1:0] stk_r [SD];
  logic [AW-1:0] path_v [SD];
  logic [AW-1:0] path_sib [SD];
  logic          path_right [SD];

  logic          push_en, path_we;
  logic [AW-1:0] push_v;
  logic [IW-1:0] push_tl, push_tr, push_r;
  logic [PW-1:0] top_idx;

  logic [IW-1:0] tm;
  logic [AW-1:0] half, rc;
  logic          first_ok, last_ok, full, go_l, go_r, dir;
  span_t         rd_span, leaf, up_span;
  logic signed [NW-1:0] val_x;
  logic [NW-1:0] inn_u;
  logic [BEST_W-1:0] best_sat;

  assign rd_span = span_t'(mem_rdata_i);
  assign top_idx = PW'(sp_q - SPW'(1));

  // Node geometry: midpoint and right child address.
  assign tm   = IW'(({1'b0, tl_q} + {1'b0, tr_q}) >> 1);
  assign half = AW'(tm) - AW'(tl_q) + AW'(1);
  assign rc   = v_q + (half << 1);
  assign full = (l_q == tl_q) && (r_q == tr_q);
  assign go_l = (l_q <= tm);
  assign go_r = (r_q > tm);
  assign dir  = (l_q > tm);

  // Range checks against min(element_count, CAPACITY).
  assign first_ok = ({1'b0, first_index_i} < element_count_i) &&
                    (32'(first_index_i) < 32'(CAPACITY));
  assign last_ok  = ({1'b0, last_index_i} < element_count_i) &&
                    (32'(last_index_i) < 32'(CAPACITY));

  // Leaf span of the written value; the empty choice counts as zero.
  assign val_x    = NW'(val_q);
  assign leaf.tot = val_x;
  assign leaf.pre = (val_x > 0) ? val_x : '0;
  assign leaf.suf = (val_x > 0) ? val_x : '0;
  assign leaf.inn = (val_x > 0) ? val_x : '0;

  assign up_span = path_right[wd_q] ? span_merge(rd_span, carry_q)
                                    : span_merge(carry_q, rd_span);

  // Best sum, saturated to the field.
  assign inn_u    = $unsigned(acc_q.inn);
  assign best_sat = ((inn_u >> BEST_W) != '0) ? '1 : BEST_W'(inn_u);

  // Sequencer: next state, memory accesses and datapath updates.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    v_d         = v_q;
    tl_d        = tl_q;
    tr_d        = tr_q;
    l_d         = l_q;
    r_d         = r_q;
    val_d       = val_q;
    err_d       = err_q;
    rd_pend_d   = 1'b0;
    acc_d       = rd_pend_q ? span_merge(acc_q, rd_span) : acc_q;
    carry_d     = carry_q;
    sp_d        = sp_q;
    wd_d        = wd_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_best_d  = out_best_q;
    out_err_d   = out_err_q;
    push_en     = 1'b0;
    push_v      = rc;
    push_tl     = tm + IW'(1);
    push_tr     = tr_q;
    push_r      = r_q;
    path_we     = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = v_q;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = v_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(2 * CAPACITY - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          v_d   = AW'(1);
          tl_d  = '0;
          tr_d  = IW'(CAPACITY - 1);
          l_d   = IW'(first_index_i);
          r_d   = IW'(last_index_i);
          val_d = value_i;
          acc_d = '0;
          sp_d  = '0;
          wd_d  = '0;
          err_d = 1'b0;
          if (action_i == ACT_WRITE) begin
            if (first_ok) begin
              state_d = ST_WDOWN;
            end else begin
              err_d   = 1'b1;
              state_d = ST_DONE;
            end
          end else if (!(first_ok && last_ok)) begin
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else if (first_index_i > last_index_i) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_QSTEP;
          end
        end
      end
      ST_WDOWN: begin
        if (tl_q == tr_q) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = leaf;
          carry_d     = leaf;
          wd_d        = wd_q - PW'(1);
          state_d     = ST_WUPRD;
        end else begin
          path_we = 1'b1;
          wd_d    = wd_q + PW'(1);
          if (dir) begin
            v_d  = rc;
            tl_d = tm + IW'(1);
          end else begin
            v_d  = v_q + AW'(1);
            tr_d = tm;
          end
        end
      end
      ST_WUPRD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = path_sib[wd_q];
        state_d     = ST_WUPWR;
      end
      ST_WUPWR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = path_v[wd_q];
        mem_wdata_o = up_span;
        carry_d     = up_span;
        if (wd_q == '0) begin
          state_d = ST_DONE;
        end else begin
          wd_d    = wd_q - PW'(1);
          state_d = ST_WUPRD;
        end
      end
      ST_QSTEP: begin
        if (full) begin
          // Covered node: fetch it and fold it in next cycle.
          mem_re_o    = 1'b1;
          mem_raddr_o = v_q;
          rd_pend_d   = 1'b1;
          if (sp_q == '0) begin
            state_d = ST_QTAIL;
          end else begin
            sp_d = sp_q - SPW'(1);
            v_d  = stk_v[top_idx];
            tl_d = stk_tl[top_idx];
            tr_d = stk_tr[top_idx];
            l_d  = stk_tl[top_idx];
            r_d  = stk_r[top_idx];
          end
        end else if (go_l && go_r) begin
          push_en = 1'b1;
          sp_d    = sp_q + SPW'(1);
          v_d     = v_q + AW'(1);
          tr_d    = tm;
          r_d     = tm;
        end else if (go_l) begin
          v_d  = v_q + AW'(1);
          tr_d = tm;
        end else begin
          v_d  = rc;
          tl_d = tm + IW'(1);
        end
      end
      ST_QTAIL: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_best_d  = best_sat;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      wd_q        <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      wd_q        <= wd_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers, stack and path entries.
  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    tl_q       <= tl_d;
    tr_q       <= tr_d;
    l_q        <= l_d;
    r_q        <= r_d;
    val_q      <= val_d;
    err_q      <= err_d;
    acc_q      <= acc_d;
    carry_q    <= carry_d;
    out_best_q <= out_best_d;
    out_err_q  <= out_err_d;
    if (push_en) begin
      stk_v[sp_q[PW-1:0]]  <= push_v;
      stk_tl[sp_q[PW-1:0]] <= push_tl;
      stk_tr[sp_q[PW-1:0]] <= push_tr;
      stk_r[sp_q[PW-1:0]]  <= push_r;
    end
    if (path_we) begin
      path_v[wd_q]     <= v_q;
      path_sib[wd_q]   <= dir ? (v_q + AW'(1)) : rc;
      path_right[wd_q] <= dir;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign best_sum_o    = out_best_q;
  assign range_error_o = out_err_q;

endmodule

/* hw/rtl/max_subarray_segment_tree_core.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  action, first_index, last_index, value
// out       output     out_valid_o/out_stall_i best_sum, range_error
// apb       input      psel/penable/pready    element_count at byte address 0
//
// One transaction at a time. A write walks down the tree one level per step, then does a
// sibling read and a write back per level in the node memory.
// A query visits each node of its descent once and reads each covered node from memory once.
// After reset all 2*CAPACITY node memory entries are cleared while in_stall_o stays high.
// A finished result waits in the output register while out_stall_i is high.
module max_subarray_segment_tree_core
  import mss_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    action_i,
  input  logic [IDX_W-1:0]        first_index_i,
  input  logic [IDX_W-1:0]        last_index_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [BEST_W-1:0]       best_sum_o,
  output logic                    range_error_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned AW = $clog2(2 * CAPACITY);
  localparam int unsigned NW = VAL_W + IW;

  logic [CNT_W-1:0] element_count;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [4*NW-1:0]  mem_wdata, mem_rdata;

  // Configuration register.
  mss_apb u_apb (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .element_count_o (element_count)
  );

  // Tree walker.
  mss_engine #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .AW       (AW),
    .NW       (NW)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_count_i (element_count),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .first_index_i   (first_index_i),
    .last_index_i    (last_index_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .best_sum_o      (best_sum_o),
    .range_error_o   (range_error_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  // Node memory: total, prefix, suffix and inner sums packed per node.
  mss_ram #(
    .WIDTH (4 * NW),
    .DEPTH (2 * CAPACITY)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* hw/rtl/mss_checker.sv */
module mss_checker
  import mss_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [BEST_W-1:0] best_sum_o,
  input logic              range_error_o
);

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(best_sum_o) &&
    $stable(range_error_o))
    else $error("stalled result changed");

  // An out-of-range transaction never reports a sum.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> best_sum_o == '0)
    else $error("range error with nonzero sum");

  // The block works on one transaction at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

endmodule

bind max_subarray_segment_tree_core mss_checker u_mss_checker (.*);

/* tb/max_subarray_segment_tree_core_tb.sv */
`timescale 1ns / 100ps

module max_subarray_segment_tree_core_tb;
  import mss_pkg::*;

  localparam int unsigned SIZE       = CAPACITY_DEF;
  localparam int unsigned CYCLE_CAP  = 1_000_000;
  localparam int unsigned RAND_ITEMS = 2000;
  localparam int unsigned PHASE_LEN  = 250;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              act;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  last;
    logic [VAL_W-1:0]  value;
    logic              typed;
    logic [BEST_W-1:0] best;
    logic              err;
  } stim_row_t;

  typedef struct packed {
    logic [BEST_W-1:0] best;
    logic              err;
  } sum_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    action_i = ACT_WRITE;
  logic [IDX_W-1:0]        first_index_i = '0;
  logic [IDX_W-1:0]        last_index_i = '0;
  logic signed [VAL_W-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [BEST_W-1:0]       best_sum_o;
  logic                    range_error_o;

  // Shadow copy of the array and of the element count register.
  logic signed [VAL_W-1:0] shadow_elems [SIZE];
  logic [CNT_W-1:0]        shadow_count;
  sum_result_t             pending_sums [$];
  int unsigned             fail_count = 0;
  int unsigned             cycle_count = 0;
  int unsigned             drain_wait = 0;
  bit                      calm = 1'b0;

  max_subarray_segment_tree_core uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("max_subarray_segment_tree_core_tb NOT OK");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic int unsigned active_limit();
    return (shadow_count < SIZE) ? shadow_count : SIZE;
  endfunction

  // Best subsegment sum over first..last, empty counting as zero.
  function automatic logic [BEST_W-1:0] best_in_range(int unsigned first, int unsigned last);
    longint run_sum;
    longint best;
    run_sum = 0;
    best = 0;
    for (int unsigned k = first; k <= last; k++) begin
      run_sum = run_sum + longint'(shadow_elems[k]);
      if (run_sum < 0) run_sum = 0;
      if (run_sum > best) best = run_sum;
    end
    return best[BEST_W-1:0];
  endfunction

  // Applies one accepted transaction to the shadow array and returns its result.
  function automatic sum_result_t apply_item(stim_row_t r);
    sum_result_t res;
    int unsigned lim;
    lim = active_limit();
    res = '0;
    if (r.act == ACT_WRITE) begin
      if (r.first >= lim) res.err = 1'b1;
      else shadow_elems[r.first] = r.value;
    end else if (r.first >= lim || r.last >= lim) begin
      res.err = 1'b1;
    end else if (r.first <= r.last) begin
      res.best = best_in_range(r.first, r.last);
    end
    return res;
  endfunction

  // Drives one transaction and records its expected result at acceptance.
  task automatic send_item(stim_row_t r);
    int unsigned gap;
    sum_result_t res;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    action_i      <= r.act;
    first_index_i <= r.first;
    last_index_i  <= r.last;
    value_i       <= r.value;
    do @(posedge clk_i); while (in_stall_o);
    res = apply_item(r);
    if (r.typed && (res.best !== r.best || res.err !== r.err))
      $display("%0t: table row predicts best %0d err %0d, predictor gives %0d err %0d",
               $time, r.best, r.err, res.best, res.err);
    pending_sums.push_back(r.typed ? {r.best, r.err} : res);
  endtask

  // Waits for the block to drain, then writes and reads back element_count.
  task automatic write_count(logic [CNT_W-1:0] count);
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_ELEMENT_COUNT, 2'b00};
    pwdata <= DATA_W'(count);
    @(negedge clk_i) penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== DATA_W'(count)) begin
      $display("%0t: element_count readback expected %0d actual %0d", $time, count, prdata);
      fail_count++;
    end
    @(negedge clk_i) begin
      psel <= 1'b0; penable <= 1'b0;
    end
    shadow_count = count;
  endtask

  function automatic logic [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return VAL_W'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom();
    endcase
  endfunction

  // Mostly in-range writes and queries, with some noise and reversed ranges.
  function automatic stim_row_t draw_item();
    stim_row_t r;
    int unsigned lim;
    int unsigned a;
    int unsigned b;
    lim = active_limit();
    r = '0;
    r.kind  = ROW_ITEM;
    r.act   = ($urandom_range(0, 1) == 0) ? ACT_WRITE : ACT_QUERY;
    r.value = draw_value();
    r.first = IDX_W'($urandom());
    r.last  = IDX_W'($urandom());
    if (lim > 0 && $urandom_range(0, 9) < 8) begin
      a = $urandom_range(0, lim - 1);
      b = $urandom_range(0, lim - 1);
      if ($urandom_range(0, 9) == 0) begin
        r.first = IDX_W'((a > b) ? a : b);
        r.last  = IDX_W'((a > b) ? b : a);
      end else begin
        r.first = IDX_W'((a < b) ? a : b);
        r.last  = IDX_W'((a < b) ? b : a);
      end
    end
    return r;
  endfunction

  // Output checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      drain_wait = draw_gap();
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result best %0d err %0d", $time, best_sum_o, range_error_o);
        fail_count++;
      end else begin
        if (best_sum_o !== pending_sums[0].best) begin
          $display("%0t: best_sum expected %0d actual %0d",
                   $time, pending_sums[0].best, best_sum_o);
          fail_count++;
        end
        if (range_error_o !== pending_sums[0].err) begin
          $display("%0t: range_error expected %0d actual %0d",
                   $time, pending_sums[0].err, range_error_o);
          fail_count++;
        end
        void'(pending_sums.pop_front());
      end
    end
  end

  // Receiver stall pattern.
  always @(negedge clk_i) begin
    out_stall_i <= (drain_wait > 0);
    if (drain_wait > 0) drain_wait = drain_wait - 1;
  end

  // Directed table: reset state, value extremes, reversed and out-of-range
  // queries, zero and oversized element counts.
  stim_row_t directed [] = '{
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd1023, 32'h0,         1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_WRITE, 10'd0,    10'd0,    32'h7FFF_FFFF, 1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_WRITE, 10'd1023, 10'd0,    32'h8000_0000, 1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd1023, 32'hFFFF_FFFF, 1'b1, 41'd2147483647, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd5,    10'd2,    32'h0,         1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_WRITE, 10'd512,  10'd1023, 32'hFFFF_FFFF, 1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd1023, 10'd1023, 32'h0,         1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_WRITE, 10'd1,    10'd0,    32'h7FFF_FFFF, 1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd600,  32'h0,         1'b0, 41'd0, 1'b0},
    '{ROW_CFG,  ACT_WRITE, 10'd0,    10'd0,    32'd16,        1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_WRITE, 10'd16,   10'd0,    32'd5,         1'b1, 41'd0, 1'b1},
    '{ROW_ITEM, ACT_QUERY, 10'd3,    10'd16,   32'h0,         1'b1, 41'd0, 1'b1},
    '{ROW_ITEM, ACT_QUERY, 10'd16,   10'd3,    32'h0,         1'b1, 41'd0, 1'b1},
    '{ROW_ITEM, ACT_WRITE, 10'd15,   10'd0,    32'd9,         1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd15,   32'h0,         1'b0, 41'd0, 1'b0},
    '{ROW_CFG,  ACT_WRITE, 10'd0,    10'd0,    32'd0,         1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_WRITE, 10'd0,    10'd0,    32'd1,         1'b1, 41'd0, 1'b1},
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd0,    32'h0,         1'b1, 41'd0, 1'b1},
    '{ROW_CFG,  ACT_WRITE, 10'd0,    10'd0,    32'd2047,      1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_WRITE, 10'd1022, 10'd0,    32'h7FFF_FFFF, 1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd1023, 32'h0,         1'b0, 41'd0, 1'b0},
    '{ROW_CFG,  ACT_WRITE, 10'd0,    10'd0,    32'd1,         1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_QUERY, 10'd0,    10'd0,    32'h0,         1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, ACT_WRITE, 10'd1,    10'd0,    32'd3,         1'b1, 41'd0, 1'b1}
  };

  // Element counts for the random phases, extremes included.
  logic [CNT_W-1:0] phase_counts [] = '{11'd1024, 11'd1, 11'd37, 11'd2047, 11'd0,
                                        11'd300, 11'd1023, 11'd2, 11'd1024};

  initial begin
    int unsigned sent;
    for (int k = 0; k < SIZE; k++) shadow_elems[k] = '0;
    shadow_count = EC_RESET;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (directed[k]) begin
      if (directed[k].kind == ROW_CFG) write_count(directed[k].value[CNT_W-1:0]);
      else send_item(directed[k]);
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      write_count(phase_counts[(sent / PHASE_LEN) % phase_counts.size()]);
      for (int k = 0; k < PHASE_LEN && sent < RAND_ITEMS; k++) begin
        if (k % 80 == 0) calm = ($urandom_range(0, 3) == 0);
        send_item(draw_item());
        sent++;
      end
    end
    calm = 1'b0;

    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("max_subarray_segment_tree_core_tb OK");
    end else begin
      $display("max_subarray_segment_tree_core_tb NOT OK");
    end
    $finish;
  end

endmodule
